>>> rtl/core/rca_pkg.sv
// Package for the RGB565 color adjust block: constants, register codes, shared types
// and the small arithmetic helpers used in the pipeline stages.
// Depends on nothing; every other file of the block uses it.
package rca_pkg;

    localparam int COLOR_W    = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;
    localparam int SC_W       = 11;
    localparam int DIV_STAGES = 8;
    localparam int DIV_FIRST  = 5;
    localparam int N_STAGES   = DIV_FIRST + DIV_STAGES + 6;
    localparam int HUE_NUM_W  = 15;
    localparam int HUE_DEN_W  = 8;
    localparam int SAT_NUM_W  = 17;
    localparam int SAT_DEN_W  = 9;

    localparam logic [12:0] RECIP100 = 13'd5243;
    localparam logic [20:0] RECIP_RB = 21'd1122868;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RED_OFS  = 3'd0,
        REG_GRN_OFS  = 3'd1,
        REG_BLU_OFS  = 3'd2,
        REG_BRIGHT   = 3'd3,
        REG_CONTRAST = 3'd4,
        REG_HUE_ROT  = 3'd5,
        REG_SAT      = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic [7:0] l;
        logic [8:0] hoff;
        logic       red;
        logic       grey;
        logic       last;
    } div_side_t;

    function automatic logic [7:0] expand5(input logic [4:0] x);
        logic [7:0] y;
        logic [7:0] s;
        y = 8'(x) * 8'd7;
        s = y + 8'd1 + (y >> 5);
        return {x, 3'b000} + (s >> 5);
    endfunction

    function automatic logic [7:0] expand6(input logic [5:0] x);
        logic [7:0] q;
        q = (x >= 6'd63) ? 8'd3 : (x >= 6'd42) ? 8'd2 : (x >= 6'd21) ? 8'd1 : 8'd0;
        return {x, 2'b00} + q;
    endfunction

    function automatic logic [7:0] div255(input logic [13:0] t);
        logic [14:0] s;
        s = 15'(t) + 15'd1 + 15'(t >> 8);
        return 8'(s >> 8);
    endfunction

    function automatic logic [4:0] pack5(input logic [7:0] v);
        logic [13:0] t;
        t = {1'b0, v, 5'b00000} - 14'(v);
        return 5'(div255(t));
    endfunction

    function automatic logic [5:0] pack6(input logic [7:0] v);
        logic [13:0] t;
        t = {v, 6'b000000} - 14'(v);
        return 6'(div255(t));
    endfunction

    function automatic logic signed [SC_W-1:0] scale_pct(input logic signed [8:0] s);
        logic [8:0]  a;
        logic [16:0] t;
        logic [29:0] p;
        logic [SC_W-1:0] m;
        a = s[8] ? 9'(-s) : 9'(s);
        t = 17'(a) * 17'd255;
        p = 30'(t) * 30'(RECIP100);
        m = p[29:19];
        return s[8] ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic [7:0] clamp8(input logic signed [11:0] v);
        logic [7:0] r;
        if (v < 0)
        begin
            r = 8'd0;
        end
        else if (v > 12'sd255)
        begin
            r = 8'd255;
        end
        else
        begin
            r = v[7:0];
        end
        return r;
    endfunction

endpackage

>>> rtl/core/rca_if.sv
// Stream interfaces for the RGB565 color adjust block: input and output words.
// Depends on rca_pkg for the color width.
interface rca_in_if;
    logic                         valid;
    logic                         ready;
    logic [rca_pkg::COLOR_W-1:0]  color_in;
    logic                         last_in;
    modport source (output valid, output color_in, output last_in, input ready);
    modport sink (input valid, input color_in, input last_in, output ready);
endinterface

interface rca_out_if;
    logic                         valid;
    logic                         ready;
    logic [rca_pkg::COLOR_W-1:0]  color_out;
    logic                         last_out;
    modport source (output valid, output color_out, output last_out, input ready);
    modport sink (input valid, input color_out, input last_out, output ready);
endinterface

>>> rtl/core/rca_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on rca_pkg; stage enables come from the pipeline control of the top level.
module rca_div #(
    parameter int NUM_W = rca_pkg::HUE_NUM_W,
    parameter int DEN_W = rca_pkg::HUE_DEN_W
) (
    input  logic                           clk,
    input  logic [rca_pkg::DIV_STAGES-1:0] en,
    input  logic [NUM_W-1:0]               num,
    input  logic [DEN_W-1:0]               den,
    output logic [rca_pkg::DIV_STAGES-1:0] quo
);
    import rca_pkg::*;

    localparam int S = DIV_STAGES;
    localparam int W = (NUM_W > DEN_W + S) ? NUM_W : DEN_W + S;

    logic [W-1:0]     rem_reg [S-1];
    logic [DEN_W-1:0] den_reg [S-1];
    logic [S-1:0]     quo_reg [S];

    for (genvar j = 0; j < S; j++)
    begin : g_stage
        logic [W-1:0]     rem_in;
        logic [DEN_W-1:0] den_in;
        logic [S-1:0]     quo_in;
        logic [W-1:0]     trial;
        logic             ge;

        if (j == 0)
        begin : g_first
            assign rem_in = W'(num);
            assign den_in = den;
            assign quo_in = '0;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[j-1];
            assign den_in = den_reg[j-1];
            assign quo_in = quo_reg[j-1];
        end

        assign trial = W'(den_in) << (S - 1 - j);
        assign ge    = (rem_in >= trial);

        always_ff @(posedge clk)
        begin
            if (en[j])
            begin
                quo_reg[j] <= {quo_in[S-2:0], ge};
            end
        end

        if (j < S - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en[j])
                begin
                    rem_reg[j] <= ge ? rem_in - trial : rem_in;
                    den_reg[j] <= den_in;
                end
            end
        end
    end

    assign quo = quo_reg[S-1];

endmodule

>>> rtl/core/rgb565_color_adjust.sv
// Top level of the RGB565 color adjust block: contrast, brightness, offsets, HSL
// hue and saturation adjust. Depends on rca_pkg, rca_if and rca_div.
//
//   channel   direction   word                       handshake
//   in_ch     in          color_in[15:0], last_in    valid/ready
//   out_ch    out         color_out[15:0], last_out  valid/ready
//   cfg       in          cfg_index[2:0], cfg_data   cfg_we, no back-pressure
//
// One word enters per cycle while no stall holds the input; each word passes through every
// pipeline stage, among them the stages of the two parallel dividers for hue and saturation.
// Reset clears the valid bits and the configuration registers; data registers are not reset.
// Each stage holds while the next is full and stalled, so bubbles close up and
// input is taken while a finished word waits at the output, as long as one stage is empty.
module rgb565_color_adjust (
    input  logic                           clk,
    input  logic                           rst_n,
    rca_in_if.sink                         in_ch,
    rca_out_if.source                      out_ch,
    input  logic                           cfg_we,
    input  logic [rca_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rca_pkg::CFG_DATA_W-1:0] cfg_data
);
    import rca_pkg::*;

    localparam int N = N_STAGES;
    localparam int P6 = DIV_FIRST + DIV_STAGES;

    logic signed [7:0] red_ofs_reg, grn_ofs_reg, blu_ofs_reg;
    logic signed [7:0] bright_reg, contrast_reg, sat_reg;
    logic signed [8:0] hue_rot_reg;
    logic signed [SC_W-1:0] ofs_sc_reg [3];
    logic signed [SC_W-1:0] bright_sc_reg, sat_sc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            red_ofs_reg  <= '0;
            grn_ofs_reg  <= '0;
            blu_ofs_reg  <= '0;
            bright_reg   <= '0;
            contrast_reg <= '0;
            hue_rot_reg  <= '0;
            sat_reg      <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                REG_RED_OFS:  red_ofs_reg  <= cfg_data[7:0];
                REG_GRN_OFS:  grn_ofs_reg  <= cfg_data[7:0];
                REG_BLU_OFS:  blu_ofs_reg  <= cfg_data[7:0];
                REG_BRIGHT:   bright_reg   <= cfg_data[7:0];
                REG_CONTRAST: contrast_reg <= cfg_data[7:0];
                REG_HUE_ROT:  hue_rot_reg  <= cfg_data;
                REG_SAT:      sat_reg      <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ofs_sc_reg[0] <= '0;
            ofs_sc_reg[1] <= '0;
            ofs_sc_reg[2] <= '0;
            bright_sc_reg <= '0;
            sat_sc_reg    <= '0;
        end
        else
        begin
            ofs_sc_reg[0] <= scale_pct({red_ofs_reg[7], red_ofs_reg});
            ofs_sc_reg[1] <= scale_pct({grn_ofs_reg[7], grn_ofs_reg});
            ofs_sc_reg[2] <= scale_pct({blu_ofs_reg[7], blu_ofs_reg});
            bright_sc_reg <= scale_pct({bright_reg[7], bright_reg});
            sat_sc_reg    <= scale_pct({sat_reg[7], sat_reg});
        end
    end

    // Pipeline control: a stage loads when it is empty or its successor loads.
    logic [N-1:0] v_reg;
    logic [N-1:0] en;

    always_comb
    begin
        en[N-1] = !v_reg[N-1] || out_ch.ready;
        for (int i = N - 2; i >= 0; i--)
        begin
            en[i] = !v_reg[i] || en[i+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= in_ch.valid;
            end
            for (int i = 1; i < N; i++)
            begin
                if (en[i])
                begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    assign in_ch.ready = en[0];

    // Stage 0: expand to 8 bits and form the contrast product.
    logic [7:0]         exp_c [3];
    logic signed [8:0]  gain;
    logic signed [8:0]  xm [3];
    logic signed [17:0] p0_prod_next [3];
    logic signed [17:0] p0_prod_reg [3];
    logic               p0_last_reg;

    assign exp_c[0] = expand5(in_ch.color_in[15:11]);
    assign exp_c[1] = expand6(in_ch.color_in[10:5]);
    assign exp_c[2] = expand5(in_ch.color_in[4:0]);
    assign gain     = {contrast_reg[7], contrast_reg} + 9'sd100;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            xm[i]           = $signed({1'b0, exp_c[i]}) - 9'sd128;
            p0_prod_next[i] = 18'(gain) * 18'(xm[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            p0_prod_reg <= p0_prod_next;
            p0_last_reg <= in_ch.last_in;
        end
    end

    // Stage 1: offset and divide by 100 through a reciprocal product.
    logic signed [17:0] n1 [3];
    logic [27:0]        p1_qm_next [3];
    logic [27:0]        p1_qm_reg [3];
    logic [2:0]         p1_neg_next, p1_over_next, p1_neg_reg, p1_over_reg;
    logic               p1_last_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            n1[i]           = p0_prod_reg[i] + 18'sd12800;
            p1_neg_next[i]  = n1[i][17];
            p1_over_next[i] = !n1[i][17] && (n1[i] >= 18'sd25600);
            p1_qm_next[i]   = {13'd0, n1[i][14:0]} * 28'(RECIP100);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            p1_qm_reg   <= p1_qm_next;
            p1_neg_reg  <= p1_neg_next;
            p1_over_reg <= p1_over_next;
            p1_last_reg <= p0_last_reg;
        end
    end

    // Stage 2: clamp, then brightness and channel offsets.
    logic [7:0] y2 [3];
    logic [7:0] b2 [3];
    logic [7:0] p2_ch_next [3];
    logic [7:0] p2_ch_reg [3];
    logic       p2_last_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            y2[i] = p1_neg_reg[i] ? 8'd0 : p1_over_reg[i] ? 8'd255 : p1_qm_reg[i][26:19];
            b2[i] = clamp8($signed({4'd0, y2[i]}) + 12'(bright_sc_reg));
            p2_ch_next[i] = clamp8($signed({4'd0, b2[i]}) + 12'(ofs_sc_reg[i]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            p2_ch_reg   <= p2_ch_next;
            p2_last_reg <= p1_last_reg;
        end
    end

    // Stage 3: maximum, minimum and the hue sector.
    logic [7:0]        mx3, mn3;
    logic signed [8:0] delta3;
    logic [8:0]        hoff3;
    logic              red3;
    logic [7:0]        p3_mx_reg, p3_mn_reg;
    logic signed [8:0] p3_delta_reg;
    logic [8:0]        p3_hoff_reg;
    logic              p3_red_reg, p3_last_reg;

    always_comb
    begin
        mx3 = p2_ch_reg[0];
        mn3 = p2_ch_reg[0];
        for (int i = 1; i < 3; i++)
        begin
            if (p2_ch_reg[i] > mx3)
            begin
                mx3 = p2_ch_reg[i];
            end
            if (p2_ch_reg[i] < mn3)
            begin
                mn3 = p2_ch_reg[i];
            end
        end
        red3 = 1'b0;
        if (mx3 == p2_ch_reg[0])
        begin
            red3   = 1'b1;
            hoff3  = 9'd300;
            delta3 = $signed({1'b0, p2_ch_reg[1]}) - $signed({1'b0, p2_ch_reg[2]});
        end
        else if (mx3 == p2_ch_reg[1])
        begin
            hoff3  = 9'd60;
            delta3 = $signed({1'b0, p2_ch_reg[2]}) - $signed({1'b0, p2_ch_reg[0]});
        end
        else
        begin
            hoff3  = 9'd180;
            delta3 = $signed({1'b0, p2_ch_reg[0]}) - $signed({1'b0, p2_ch_reg[1]});
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            p3_mx_reg    <= mx3;
            p3_mn_reg    <= mn3;
            p3_delta_reg <= delta3;
            p3_hoff_reg  <= hoff3;
            p3_red_reg   <= red3;
            p3_last_reg  <= p2_last_reg;
        end
    end

    // Stage 4: lightness and the dividend and divisor of hue and saturation.
    logic [7:0]            d4;
    logic [8:0]            sum4;
    logic [7:0]            den4;
    logic signed [9:0]     tsum4;
    logic [HUE_NUM_W-1:0]  p4_tnum_reg;
    logic [HUE_DEN_W-1:0]  p4_d_reg;
    logic [SAT_NUM_W-1:0]  p4_snum_reg;
    logic [SAT_DEN_W-1:0]  p4_sdiv_reg;
    div_side_t             p4_side_reg;
    logic [HUE_NUM_W-1:0]  tnum4;
    logic [SAT_NUM_W-1:0]  snum4;

    always_comb
    begin
        d4    = p3_mx_reg - p3_mn_reg;
        sum4  = {1'b0, p3_mx_reg} + {1'b0, p3_mn_reg};
        den4  = (sum4 <= 9'd255) ? sum4[7:0] : 8'(9'd510 - sum4);
        tsum4 = $signed({p3_delta_reg[8], p3_delta_reg}) + $signed({2'b00, d4});
        tnum4 = HUE_NUM_W'(tsum4[8:0]) * HUE_NUM_W'(60);
        snum4 = SAT_NUM_W'(d4) * SAT_NUM_W'(510) + SAT_NUM_W'(den4);
    end

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            p4_tnum_reg      <= tnum4;
            p4_d_reg         <= d4;
            p4_snum_reg      <= snum4;
            p4_sdiv_reg      <= {den4, 1'b0};
            p4_side_reg.l    <= sum4[8:1];
            p4_side_reg.hoff <= p3_hoff_reg;
            p4_side_reg.red  <= p3_red_reg;
            p4_side_reg.grey <= (d4 == 8'd0);
            p4_side_reg.last <= p3_last_reg;
        end
    end

    // Dividers and the side data that travels beside them.
    logic [DIV_STAGES-1:0] hue_q, sat_q;
    div_side_t             side_reg [DIV_STAGES];

    rca_div #(.NUM_W(HUE_NUM_W), .DEN_W(HUE_DEN_W)) u_hue_div (
        .clk (clk),
        .en  (en[DIV_FIRST +: DIV_STAGES]),
        .num (p4_tnum_reg),
        .den (p4_d_reg),
        .quo (hue_q)
    );

    rca_div #(.NUM_W(SAT_NUM_W), .DEN_W(SAT_DEN_W)) u_sat_div (
        .clk (clk),
        .en  (en[DIV_FIRST +: DIV_STAGES]),
        .num (p4_snum_reg),
        .den (p4_sdiv_reg),
        .quo (sat_q)
    );

    always_ff @(posedge clk)
    begin
        if (en[DIV_FIRST])
        begin
            side_reg[0] <= p4_side_reg;
        end
        for (int j = 1; j < DIV_STAGES; j++)
        begin
            if (en[DIV_FIRST + j])
            begin
                side_reg[j] <= side_reg[j-1];
            end
        end
    end

    // Hue rotation, saturation shift and the chroma factor.
    div_side_t          sd;
    logic [9:0]         h0, hb, hv;
    logic signed [11:0] hsum;
    logic [8:0]         hn;
    logic [7:0]         s6, q6;
    logic [8:0]         p6_h_reg;
    logic [7:0]         p6_s_reg, p6_q_reg, p6_l_reg;
    logic               p6_last_reg;

    always_comb
    begin
        sd = side_reg[DIV_STAGES-1];
        h0 = 10'(sd.hoff) + 10'(hue_q);
        if (sd.red && h0 >= 10'd360)
        begin
            h0 = h0 - 10'd360;
        end
        hb   = sd.grey ? 10'd359 : h0 + 10'd360;
        hsum = $signed({2'b00, hb}) + 12'(hue_rot_reg);
        hv   = hsum[9:0];
        if (hv >= 10'd720)
        begin
            hn = 9'(hv - 10'd720);
        end
        else if (hv >= 10'd360)
        begin
            hn = 9'(hv - 10'd360);
        end
        else
        begin
            hn = hv[8:0];
        end
        s6 = sd.grey ? 8'd0 : sat_q;
        q6 = sd.l[7] ? 8'(9'd510 - {sd.l, 1'b0}) : {sd.l[6:0], 1'b0};
    end

    always_ff @(posedge clk)
    begin
        if (en[P6])
        begin
            p6_h_reg    <= hn;
            p6_s_reg    <= clamp8($signed({4'd0, s6}) + 12'(sat_sc_reg));
            p6_q_reg    <= q6;
            p6_l_reg    <= sd.l;
            p6_last_reg <= sd.last;
        end
    end

    // Sector, fraction within the sector, and chroma product.
    logic [2:0]  k7;
    logic [8:0]  kb7;
    logic [5:0]  f7;
    logic [2:0]  p7_k_reg;
    logic [5:0]  p7_fac_reg;
    logic [15:0] p7_qs_reg;
    logic [7:0]  p7_l_reg;
    logic        p7_last_reg;

    always_comb
    begin
        if (p6_h_reg >= 9'd300)
        begin
            k7 = 3'd5; kb7 = 9'd300;
        end
        else if (p6_h_reg >= 9'd240)
        begin
            k7 = 3'd4; kb7 = 9'd240;
        end
        else if (p6_h_reg >= 9'd180)
        begin
            k7 = 3'd3; kb7 = 9'd180;
        end
        else if (p6_h_reg >= 9'd120)
        begin
            k7 = 3'd2; kb7 = 9'd120;
        end
        else if (p6_h_reg >= 9'd60)
        begin
            k7 = 3'd1; kb7 = 9'd60;
        end
        else
        begin
            k7 = 3'd0; kb7 = 9'd0;
        end
        f7 = 6'(p6_h_reg - kb7);
    end

    always_ff @(posedge clk)
    begin
        if (en[P6+1])
        begin
            p7_k_reg    <= k7;
            p7_fac_reg  <= k7[0] ? 6'd60 - f7 : f7;
            p7_qs_reg   <= 16'(p6_q_reg) * 16'(p6_s_reg);
            p7_l_reg    <= p6_l_reg;
            p7_last_reg <= p6_last_reg;
        end
    end

    // Scaled chroma, intermediate and lightness terms, in units of 1/30600.
    logic [23:0] p8_cs_reg, p8_xs_reg, p8_m60_reg, p8_lm_reg;
    logic [2:0]  p8_k_reg;
    logic        p8_last_reg;

    always_ff @(posedge clk)
    begin
        if (en[P6+2])
        begin
            p8_cs_reg   <= 24'(p7_qs_reg) * 24'd120;
            p8_xs_reg   <= 24'(p7_qs_reg) * 24'({p7_fac_reg, 1'b0});
            p8_m60_reg  <= 24'(p7_qs_reg) * 24'd60;
            p8_lm_reg   <= 24'(p7_l_reg) * 24'd30600;
            p8_k_reg    <= p7_k_reg;
            p8_last_reg <= p7_last_reg;
        end
    end

    // Add the rounding offset and flag values that clamp.
    logic signed [25:0] ms9;
    logic signed [25:0] v9 [3];
    logic signed [25:0] w9 [3];
    logic [19:0]        u9 [3];
    logic [2:0]         over9;
    logic [19:0]        p9_u_reg [3];
    logic [2:0]         p9_over_reg;
    logic [2:0]         p9_k_reg;
    logic               p9_last_reg;

    always_comb
    begin
        ms9   = $signed({2'b00, p8_lm_reg}) - $signed({2'b00, p8_m60_reg});
        v9[0] = ms9 + $signed({2'b00, p8_cs_reg});
        v9[1] = ms9 + $signed({2'b00, p8_xs_reg});
        v9[2] = ms9;
        for (int i = 0; i < 3; i++)
        begin
            w9[i] = v9[i] + 26'sd15300;
            if (v9[i] < 0)
            begin
                over9[i] = 1'b0;
                u9[i]    = '0;
            end
            else
            begin
                over9[i] = (w9[i] >= 26'sd7833600);
                u9[i]    = w9[i][22:3];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[P6+3])
        begin
            p9_u_reg    <= u9;
            p9_over_reg <= over9;
            p9_k_reg    <= p8_k_reg;
            p9_last_reg <= p8_last_reg;
        end
    end

    // Divide by 30600 through a reciprocal product.
    logic [40:0] p10_prod_reg [3];
    logic [2:0]  p10_over_reg;
    logic [2:0]  p10_k_reg;
    logic        p10_last_reg;

    always_ff @(posedge clk)
    begin
        if (en[P6+4])
        begin
            for (int i = 0; i < 3; i++)
            begin
                p10_prod_reg[i] <= 41'(p9_u_reg[i]) * 41'(RECIP_RB);
            end
            p10_over_reg <= p9_over_reg;
            p10_k_reg    <= p9_k_reg;
            p10_last_reg <= p9_last_reg;
        end
    end

    // Route the three levels to the channels by sector and repack.
    logic [7:0]         lvl [3];
    logic [7:0]         rr, gg, bb;
    logic [COLOR_W-1:0] out_color_reg;
    logic               out_last_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            lvl[i] = p10_over_reg[i] ? 8'd255 : p10_prod_reg[i][39:32];
        end
        case (p10_k_reg)
            3'd0:    begin rr = lvl[0]; gg = lvl[1]; bb = lvl[2]; end
            3'd1:    begin rr = lvl[1]; gg = lvl[0]; bb = lvl[2]; end
            3'd2:    begin rr = lvl[2]; gg = lvl[0]; bb = lvl[1]; end
            3'd3:    begin rr = lvl[2]; gg = lvl[1]; bb = lvl[0]; end
            3'd4:    begin rr = lvl[1]; gg = lvl[2]; bb = lvl[0]; end
            default: begin rr = lvl[0]; gg = lvl[2]; bb = lvl[1]; end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en[N-1])
        begin
            out_color_reg <= {pack5(rr), pack6(gg), pack5(bb)};
            out_last_reg  <= p10_last_reg;
        end
    end

    assign out_ch.valid     = v_reg[N-1];
    assign out_ch.color_out = out_color_reg;
    assign out_ch.last_out  = out_last_reg;

endmodule

>>> rtl/core/rca_checker.sv
// Port-level checks for the RGB565 color adjust block, bound to its top level.
// Depends on rca_pkg for the pipeline depth.
module rca_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [rca_pkg::COLOR_W-1:0]  out_color,
    input logic                         out_last
);
    import rca_pkg::*;

    logic [5:0] inflight_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
        end
        else
        begin
            inflight_reg <= inflight_reg + 6'(in_valid && in_ready) - 6'(out_valid && out_ready);
        end
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output word dropped while stalled");

    a_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_color) && $stable(out_last))
        else $error("output word changed while stalled");

    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready |-> inflight_reg != 6'd0)
        else $error("output word without a matching input word");

    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg <= 6'(N_STAGES))
        else $error("more words in flight than pipeline stages");

    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without a stalled output");

endmodule

bind rgb565_color_adjust rca_checker u_rca_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_color (out_ch.color_out),
    .out_last  (out_ch.last_out)
);

>>> verif/rca_tb_if.sv
`timescale 1ns / 100ps
// Testbench-side note: the stream interfaces themselves live in rtl/core/rca_if.sv.
// This file holds the configuration register codes used by the testbench; depends on rca_pkg.
package rca_tb_pkg;
    import rca_pkg::*;

    localparam cfg_idx_t ALL_REGS [7] = '{REG_RED_OFS, REG_GRN_OFS, REG_BLU_OFS,
                                          REG_BRIGHT, REG_CONTRAST, REG_HUE_ROT, REG_SAT};
    localparam logic [2:0] REG_UNUSED = 3'd7;
endpackage

>>> verif/testbench.sv
`timescale 1ns / 100ps
// Testbench for rgb565_color_adjust: streams colors through under many register settings,
// predicts each adjusted color and compares. Depends on rca_pkg, rca_tb_pkg and rca_if.
module testbench;
    import rca_pkg::*;
    import rca_tb_pkg::*;

    typedef struct packed {
        logic [15:0] color;
        logic        last;
    } word_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [2:0] cfg_index = '0;
    logic [8:0] cfg_data = '0;
    int errors = 0;
    int regs [7];
    word_t pending [$];

    rca_in_if in_ch ();
    rca_out_if out_ch ();

    rgb565_color_adjust i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch.sink),
        .out_ch    (out_ch.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.color_in = '0;
        in_ch.last_in = 1'b0;
        out_ch.ready = 1'b0;
    end

    function automatic int clip(input int v);
        return v < 0 ? 0 : (v > 255 ? 255 : v);
    endfunction

    function automatic int unround(input int v);
        return v < 0 ? 0 : clip((v + 15300) / 30600);
    endfunction

    function automatic logic [15:0] adjust_color(input logic [15:0] c);
        int ch [3];
        int mx, mn, d, sum, l, s, h, q, k, f, cs, xs, ms, hi, mid, lo, den, n, v;
        int rr, gg, bb;
        ch[0] = int'(c[15:11]) * 255 / 31;
        ch[1] = int'(c[10:5]) * 255 / 63;
        ch[2] = int'(c[4:0]) * 255 / 31;
        for (int i = 0; i < 3; i++)
        begin
            n = (100 + regs[REG_CONTRAST]) * (ch[i] - 128) + 12800;
            v = n < 0 ? 0 : clip(n / 100);
            v = clip(v + regs[REG_BRIGHT] * 255 / 100);
            ch[i] = clip(v + regs[i] * 255 / 100);
        end
        mx = ch[0];
        mn = ch[0];
        for (int i = 1; i < 3; i++)
        begin
            if (ch[i] > mx) mx = ch[i];
            if (ch[i] < mn) mn = ch[i];
        end
        d = mx - mn;
        sum = mx + mn;
        l = sum / 2;
        if (d == 0)
        begin
            s = 0;
            h = -1;
        end
        else
        begin
            den = (sum <= 255) ? sum : 510 - sum;
            s = (510 * d + den) / (2 * den);
            if (s > 255) s = 255;
            if (mx == ch[0])
                h = ((360 * d + 60 * (ch[1] - ch[2])) / d) % 360;
            else if (mx == ch[1])
                h = (120 * d + 60 * (ch[2] - ch[0])) / d;
            else
                h = (240 * d + 60 * (ch[0] - ch[1])) / d;
        end
        h = (h + regs[REG_HUE_ROT] + 360) % 360;
        if (h < 0) h += 360;
        s = clip(s + regs[REG_SAT] * 255 / 100);
        q = 2 * l - 255;
        q = 255 - (q < 0 ? -q : q);
        k = h / 60;
        f = h % 60;
        cs = q * s * 120;
        xs = q * s * 2 * ((k % 2 == 1) ? (60 - f) : f);
        ms = l * 30600 - q * s * 60;
        hi = unround(ms + cs);
        mid = unround(ms + xs);
        lo = unround(ms);
        case (k)
            0: begin rr = hi; gg = mid; bb = lo; end
            1: begin rr = mid; gg = hi; bb = lo; end
            2: begin rr = lo; gg = hi; bb = mid; end
            3: begin rr = lo; gg = mid; bb = hi; end
            4: begin rr = mid; gg = lo; bb = hi; end
            default: begin rr = hi; gg = lo; bb = mid; end
        endcase
        return {5'(rr * 31 / 255), 6'(gg * 63 / 255), 5'(bb * 31 / 255)};
    endfunction

    function automatic int short_gap();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30)
             : (($urandom_range(0, 2) == 0) ? $urandom_range(0, 2) : 0);
    endfunction

    always @(posedge clk)
    begin
        word_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending.size() == 0)
            begin
                $error("color_out: no word expected, actual %h", out_ch.color_out);
                errors++;
            end
            else
            begin
                want = pending.pop_front();
                if (out_ch.color_out !== want.color)
                begin
                    $error("color_out: expected %h, actual %h", want.color, out_ch.color_out);
                    errors++;
                end
                if (out_ch.last_out !== want.last)
                begin
                    $error("last_out: expected %b, actual %b", want.last, out_ch.last_out);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        int g;
        wait (rst_n);
        forever
        begin
            g = short_gap();
            out_ch.ready <= (g == 0);
            @(posedge clk);
            for (int i = 1; i < g; i++) @(posedge clk);
            out_ch.ready <= 1'b1;
            @(posedge clk);
        end
    end

    task automatic send_color(input logic [15:0] c, input logic l);
        int g;
        word_t w;
        g = short_gap();
        if (g > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.color_in <= c;
        in_ch.last_in <= l;
        w.color = adjust_color(c);
        w.last = l;
        do @(posedge clk); while (!in_ch.ready);
        pending.push_back(w);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        wait (pending.size() == 0);
        repeat (30) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input int v);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= 9'(v);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (idx < 3'd7)
            regs[idx] = (idx == REG_HUE_ROT) ? int'($signed(9'(v))) : int'($signed(8'(v)));
    endtask

    task automatic random_colors(input int n);
        for (int i = 0; i < n; i++)
            send_color(16'($urandom()), 1'($urandom_range(0, 1)));
    endtask

    task automatic test_identity();
        logic [15:0] dir [12] = '{16'h0000, 16'hFFFF, 16'hF800, 16'h07E0, 16'h001F,
                                  16'h8410, 16'h7BEF, 16'hFFE0, 16'hF81F, 16'h07FF,
                                  16'h1234, 16'hA5A5};
        foreach (dir[i]) send_color(dir[i], i[0]);
        drain();
    endtask

    task automatic test_extremes();
        int lo [7] = '{-100, -100, -100, -100, -100, -180, -100};
        int hi [7] = '{100, 100, 100, 100, 100, 180, 100};
        foreach (ALL_REGS[i]) write_reg(ALL_REGS[i], hi[i]);
        random_colors(8);
        drain();
        foreach (ALL_REGS[i]) write_reg(ALL_REGS[i], lo[i]);
        random_colors(8);
        drain();
        write_reg(REG_UNUSED, 9'h1FF);
        write_reg(REG_SAT, 50);
        write_reg(REG_CONTRAST, 0);
        foreach (ALL_REGS[i]) if (i < 4) write_reg(ALL_REGS[i], 0);
        send_color(16'h0000, 1'b0);
        send_color(16'h8410, 1'b1);
        send_color(16'hFFFF, 1'b0);
        drain();
    endtask

    task automatic test_random_settings();
        for (int p = 0; p < 12; p++)
        begin
            foreach (ALL_REGS[i])
                write_reg(ALL_REGS[i], (p % 4 == 3) ? int'($urandom_range(0, 511))
                          : (ALL_REGS[i] == REG_HUE_ROT ? $urandom_range(0, 360) - 180
                                                        : $urandom_range(0, 200) - 100));
            random_colors(40);
            drain();
        end
    endtask

    initial
    begin
        foreach (regs[i]) regs[i] = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_identity();
        test_extremes();
        test_random_settings();
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("Some tests failed");
        $finish;
    end
endmodule

>>> sim.f
rtl/core/rca_pkg.sv
rtl/core/rca_if.sv
rtl/core/rca_div.sv
rtl/core/rgb565_color_adjust.sv
rtl/core/rca_checker.sv
verif/rca_tb_if.sv
verif/testbench.sv
